// ===== rtl/svf_pkg.sv =====
// shared types, constants and saturation helpers for the state-variable filter
package svf_pkg;

	// sizes of the datapath
	localparam int SAMPLE_WIDTH    = 24;
	localparam int COEF_FRAC_BITS  = 22;
	localparam int STATE_WIDTH     = 32;
	localparam int STATE_FRAC_BITS = SAMPLE_WIDTH - 1;
	localparam int COEF_WIDTH      = 24;
	localparam int DRIVE_WIDTH     = 19;
	localparam int MODE_WIDTH      = 3;
	localparam int MUL_W           = STATE_WIDTH + 1;
	localparam int PROD_W          = 2 * MUL_W;
	localparam int SUM_W           = STATE_WIDTH + 2;
	localparam int ACC_W           = STATE_WIDTH + 1;

	// configuration port
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FREQ_COEF   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DAMP_COEF   = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_DRIVE_COEF  = 2'd3;

	localparam logic [MODE_WIDTH-1:0]  FILTER_MODE_RST = 3'd1;
	localparam logic [COEF_WIDTH-1:0]  FREQ_COEF_RST   = 24'd143556;
	localparam logic [COEF_WIDTH-1:0]  DAMP_COEF_RST   = 24'd8388608;
	localparam logic [DRIVE_WIDTH-1:0] DRIVE_COEF_RST  = 19'd0;

	// response select codes
	localparam logic [MODE_WIDTH-1:0] MODE_NOTCH = 3'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_LOW   = 3'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_HIGH  = 3'd2;
	localparam logic [MODE_WIDTH-1:0] MODE_BAND  = 3'd3;
	localparam logic [MODE_WIDTH-1:0] MODE_PEAK  = 3'd4;

	// sequencer states
	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_RUN,
		FSM_OUT
	} fsm_t;

	// micro steps of one half step
	typedef enum logic [3:0] {
		ST_MUL_SQ,
		ST_MUL_DAMP,
		ST_NOTCH,
		ST_CUBE,
		ST_LOW,
		ST_HIGH,
		ST_MUL_HIGH,
		ST_BAND,
		ST_SEL
	} step_t;

	// sequencer to datapath controls
	typedef struct packed {
		logic  accept;
		logic  run;
		logic  half;
		step_t step;
		logic  out_phase;
		logic  load_out;
	} seq_t;

	// sign extend a state value to sum width
	function automatic logic signed [SUM_W-1:0] ext_sum(input logic signed [STATE_WIDTH-1:0] v);
		ext_sum = {{(SUM_W-STATE_WIDTH){v[STATE_WIDTH-1]}}, v};
	endfunction

	// clamp a sum to the state range
	function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-STATE_WIDTH:0] hi;
		hi = v[SUM_W-1:STATE_WIDTH-1];
		if ((&hi) || !(|hi))
			sat_state = v[STATE_WIDTH-1:0];
		else if (v[SUM_W-1])
			sat_state = {1'b1, {(STATE_WIDTH-1){1'b0}}};
		else
			sat_state = {1'b0, {(STATE_WIDTH-1){1'b1}}};
	endfunction

	// clamp a halved accumulator to the sample range
	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-SAMPLE_WIDTH:0] hi;
		hi = v[ACC_W-1:SAMPLE_WIDTH-1];
		if ((&hi) || !(|hi))
			sat_sample = v[SAMPLE_WIDTH-1:0];
		else if (v[ACC_W-1])
			sat_sample = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		else
			sat_sample = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	endfunction

endpackage

// ===== rtl/svf_in_if.sv =====
// input sample channel
interface svf_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [svf_pkg::SAMPLE_WIDTH-1:0] sample_in;
	logic                                    in_present;

	modport source(output valid, sample_in, in_present, input ready);
	modport sink(input valid, sample_in, in_present, output ready);
endinterface

// ===== rtl/svf_out_if.sv =====
// filtered sample channel
interface svf_out_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [svf_pkg::SAMPLE_WIDTH-1:0] sample_out;

	modport source(output valid, sample_out, input ready);
	modport sink(input valid, sample_out, output ready);
endinterface

// ===== rtl/double_sampled_svf_filter.sv =====
// top level of the double-sampled state-variable filter
// Usage:
//   din carries one signed Q0.23 sample per transaction, with in_present
//   forcing the sample to zero when low. dout carries the filtered sample.
//   The config port (cfg_we, cfg_addr, cfg_wdata) writes filter_mode,
//   freq_coef, damp_coef and drive_coef; write only while the filter is idle.
// Sequencing:
//   one shared multiplier does all twelve products of a sample, nine
//   micro steps per half step and two half steps per sample. After the
//   second half step the sequencer loads the output register and returns
//   to idle, where the next transaction is taken; a new sample is taken
//   only once the last one is through (din.ready is high only in the idle state).
// Reset:
//   arst_n clears the low and band integrators, loads the register defaults
//   (low-pass, 2.0 damping, no drive) and empties the output register.
// Stalls:
//   the result sits in the output register until dout.ready; a finished
//   sample waits in the sequencer while the previous result is still held.
module double_sampled_svf_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [svf_pkg::REG_IDX_W-1:0]       cfg_addr,
	input  logic [svf_pkg::COEF_WIDTH-1:0]      cfg_wdata,
	svf_in_if.sink                              din,
	svf_out_if.source                           dout
);
	localparam int SW  = svf_pkg::STATE_WIDTH;
	localparam int MW  = svf_pkg::MUL_W;
	localparam int AW  = svf_pkg::ACC_W;

	// configuration registers
	logic [svf_pkg::MODE_WIDTH-1:0]  mode_q;
	logic [svf_pkg::COEF_WIDTH-1:0]  freq_q;
	logic [svf_pkg::COEF_WIDTH-1:0]  damp_q;
	logic [svf_pkg::DRIVE_WIDTH-1:0] drive_q;

	// datapath registers
	logic signed [SW-1:0] x_q, low_q, band_q, sq_q, cube_q, notch_q, high_q, drv_q;
	logic signed [AW-1:0] acc_q;
	logic signed [svf_pkg::SAMPLE_WIDTH-1:0] odata_q;
	logic                 ovalid_q;

	svf_pkg::seq_t        seq;
	logic                 out_free;
	logic signed [MW-1:0] mul_a, mul_b;
	logic                 mul_sh;
	logic signed [SW-1:0] frac;
	logic signed [SW-1:0] peak, sel_v, band_new;

	assign out_free = !ovalid_q || dout.ready;

	svf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.out_free (out_free),
		.in_ready (din.ready),
		.seq      (seq)
	);

	// operand select for the shared multiplier
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_sh = 1'b0;
		unique case (seq.step)
			svf_pkg::ST_MUL_SQ: begin
				mul_a  = {band_q[SW-1], band_q};
				mul_b  = {band_q[SW-1], band_q};
				mul_sh = 1'b1;
			end
			svf_pkg::ST_MUL_DAMP: begin
				mul_a = $signed({{(MW-svf_pkg::COEF_WIDTH){1'b0}}, damp_q});
				mul_b = {band_q[SW-1], band_q};
			end
			svf_pkg::ST_NOTCH: begin
				mul_a  = {sq_q[SW-1], sq_q};
				mul_b  = {band_q[SW-1], band_q};
				mul_sh = 1'b1;
			end
			svf_pkg::ST_CUBE: begin
				mul_a = $signed({{(MW-svf_pkg::COEF_WIDTH){1'b0}}, freq_q});
				mul_b = {band_q[SW-1], band_q};
			end
			svf_pkg::ST_LOW: begin
				mul_a = $signed({{(MW-svf_pkg::DRIVE_WIDTH){1'b0}}, drive_q});
				mul_b = {cube_q[SW-1], cube_q};
			end
			svf_pkg::ST_MUL_HIGH: begin
				mul_a = $signed({{(MW-svf_pkg::COEF_WIDTH){1'b0}}, freq_q});
				mul_b = {high_q[SW-1], high_q};
			end
			default: begin
				mul_a  = '0;
				mul_b  = '0;
				mul_sh = 1'b0;
			end
		endcase
	end

	svf_mul u_mul (
		.clk      (clk),
		.a        (mul_a),
		.b        (mul_b),
		.sh_state (mul_sh),
		.frac     (frac)
	);

	// band update and response select
	always_comb begin
		band_new = svf_pkg::sat_state(svf_pkg::ext_sum(frac) + svf_pkg::ext_sum(band_q)
			- svf_pkg::ext_sum(drv_q));
		peak = svf_pkg::sat_state(svf_pkg::ext_sum(low_q) - svf_pkg::ext_sum(high_q));
		unique case (mode_q)
			svf_pkg::MODE_NOTCH: sel_v = notch_q;
			svf_pkg::MODE_LOW:   sel_v = low_q;
			svf_pkg::MODE_HIGH:  sel_v = high_q;
			svf_pkg::MODE_BAND:  sel_v = band_q;
			svf_pkg::MODE_PEAK:  sel_v = peak;
			default:             sel_v = '0;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= svf_pkg::FILTER_MODE_RST;
			freq_q  <= svf_pkg::FREQ_COEF_RST;
			damp_q  <= svf_pkg::DAMP_COEF_RST;
			drive_q <= svf_pkg::DRIVE_COEF_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				svf_pkg::REG_FILTER_MODE: mode_q  <= cfg_wdata[svf_pkg::MODE_WIDTH-1:0];
				svf_pkg::REG_FREQ_COEF:   freq_q  <= cfg_wdata;
				svf_pkg::REG_DAMP_COEF:   damp_q  <= cfg_wdata;
				svf_pkg::REG_DRIVE_COEF:  drive_q <= cfg_wdata[svf_pkg::DRIVE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// integrators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			band_q <= '0;
		end else if (seq.run) begin
			if (seq.step == svf_pkg::ST_LOW)
				low_q <= svf_pkg::sat_state(svf_pkg::ext_sum(low_q) + svf_pkg::ext_sum(frac));
			if (seq.step == svf_pkg::ST_BAND)
				band_q <= band_new;
		end
	end

	// working registers of a half step
	always_ff @(posedge clk) begin
		if (seq.accept) begin
			if (din.in_present)
				x_q <= {{(SW-svf_pkg::SAMPLE_WIDTH){din.sample_in[svf_pkg::SAMPLE_WIDTH-1]}},
					din.sample_in};
			else
				x_q <= '0;
		end
		if (seq.run) begin
			unique case (seq.step)
				svf_pkg::ST_MUL_DAMP: sq_q <= frac;
				svf_pkg::ST_NOTCH:
					notch_q <= svf_pkg::sat_state(svf_pkg::ext_sum(x_q) - svf_pkg::ext_sum(frac));
				svf_pkg::ST_CUBE: cube_q <= frac;
				svf_pkg::ST_HIGH: begin
					drv_q  <= frac;
					high_q <= svf_pkg::sat_state(svf_pkg::ext_sum(notch_q)
						- svf_pkg::ext_sum(low_q));
				end
				svf_pkg::ST_SEL: begin
					if (seq.half)
						acc_q <= acc_q + {sel_v[SW-1], sel_v};
					else
						acc_q <= {sel_v[SW-1], sel_v};
				end
				default: ;
			endcase
		end
		if (seq.load_out)
			odata_q <= svf_pkg::sat_sample(acc_q >>> 1);
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (seq.load_out)
			ovalid_q <= 1'b1;
		else if (dout.ready)
			ovalid_q <= 1'b0;
	end

	assign dout.valid      = ovalid_q;
	assign dout.sample_out = odata_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready) |=> !din.ready)
		else $error("input taken while a sample is in work");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready) |-> ##19 seq.out_phase)
		else $error("sample sequencing length is off");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		seq.load_out |-> (!dout.valid || dout.ready))
		else $error("output register overwritten before transaction");

	a_no_run_in_out_phase: assert property (@(posedge clk) disable iff (!arst_n)
		seq.out_phase |-> !seq.run && !din.ready)
		else $error("sequencer phases overlap");
endmodule

// ===== rtl/svf_mul.sv =====
// shared fixed-point multiplier: registered product, floor shift and saturation
module svf_mul (
	input  logic                                   clk,
	input  logic signed [svf_pkg::MUL_W-1:0]       a,
	input  logic signed [svf_pkg::MUL_W-1:0]       b,
	input  logic                                   sh_state,
	output logic signed [svf_pkg::STATE_WIDTH-1:0] frac
);
	logic signed [svf_pkg::PROD_W-1:0] prod_q;
	logic                              sh_state_q;
	logic signed [svf_pkg::PROD_W-1:0] shifted;
	logic [svf_pkg::PROD_W-svf_pkg::STATE_WIDTH:0] hi;

	// product register
	always_ff @(posedge clk) begin
		prod_q     <= a * b;
		sh_state_q <= sh_state;
	end

	// arithmetic shift rounds toward minus infinity, then clamp
	always_comb begin
		if (sh_state_q)
			shifted = prod_q >>> svf_pkg::STATE_FRAC_BITS;
		else
			shifted = prod_q >>> svf_pkg::COEF_FRAC_BITS;
		hi = shifted[svf_pkg::PROD_W-1:svf_pkg::STATE_WIDTH-1];
		if ((&hi) || !(|hi))
			frac = shifted[svf_pkg::STATE_WIDTH-1:0];
		else if (shifted[svf_pkg::PROD_W-1])
			frac = {1'b1, {(svf_pkg::STATE_WIDTH-1){1'b0}}};
		else
			frac = {1'b0, {(svf_pkg::STATE_WIDTH-1){1'b1}}};
	end
endmodule

// ===== rtl/svf_ctrl.sv =====
// sequencer: walks two half steps of micro steps per sample
module svf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_free,
	output logic                 in_ready,
	output svf_pkg::seq_t        seq
);
	svf_pkg::fsm_t  state_q, state_d;
	svf_pkg::step_t step_q, step_d;
	logic           half_q, half_d;
	logic           last_step;

	assign last_step = (step_q == svf_pkg::ST_SEL);

	// next state
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		half_d  = half_q;
		unique case (state_q)
			svf_pkg::FSM_IDLE: begin
				step_d = svf_pkg::ST_MUL_SQ;
				half_d = 1'b0;
				if (in_valid)
					state_d = svf_pkg::FSM_RUN;
			end
			svf_pkg::FSM_RUN: begin
				if (last_step) begin
					step_d = svf_pkg::ST_MUL_SQ;
					half_d = 1'b1;
					if (half_q)
						state_d = svf_pkg::FSM_OUT;
				end else begin
					step_d = svf_pkg::step_t'(step_q + 4'd1);
				end
			end
			svf_pkg::FSM_OUT: begin
				if (out_free)
					state_d = svf_pkg::FSM_IDLE;
			end
			default: state_d = svf_pkg::FSM_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = (state_q == svf_pkg::FSM_IDLE);
		seq.accept    = in_ready && in_valid;
		seq.run       = (state_q == svf_pkg::FSM_RUN);
		seq.half      = half_q;
		seq.step      = step_q;
		seq.out_phase = (state_q == svf_pkg::FSM_OUT);
		seq.load_out  = seq.out_phase && out_free;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svf_pkg::FSM_IDLE;
			step_q  <= svf_pkg::ST_MUL_SQ;
			half_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			half_q  <= half_d;
		end
	end
endmodule

// ===== sim/tb.sv =====
// testbench for the double-sampled state-variable filter: fixed-point predictor and output checker
module tb;
	import svf_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RAND_PHASES  = 12;
	localparam int PHASE_ITEMS  = 140;
	localparam int DRAIN_CYCLES = 30;
	localparam int DRIVE_TOP    = 419430;

	// expected output predictor with its own copy of the registers and integrators
	class svf_checker;
		logic [MODE_WIDTH-1:0] mode;
		longint freq;
		longint damp;
		longint drive;
		longint low_acc;
		longint band_acc;
		logic signed [SAMPLE_WIDTH-1:0] expected_out[$];
		int mismatches;
		int compared;

		function new();
			mode = FILTER_MODE_RST;
			freq = longint'(FREQ_COEF_RST);
			damp = longint'(DAMP_COEF_RST);
			drive = longint'(DRIVE_COEF_RST);
			low_acc = 0;
			band_acc = 0;
			mismatches = 0;
			compared = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [COEF_WIDTH-1:0] val);
			case (idx)
				REG_FILTER_MODE: mode = val[MODE_WIDTH-1:0];
				REG_FREQ_COEF:   freq = longint'(val);
				REG_DAMP_COEF:   damp = longint'(val);
				REG_DRIVE_COEF:  drive = longint'(val[DRIVE_WIDTH-1:0]);
				default: ;
			endcase
		endfunction

		function longint clamp_state(longint v);
			longint top;
			top = (longint'(1) << (STATE_WIDTH - 1)) - 1;
			if (v > top)
				return top;
			if (v < -top - 1)
				return -top - 1;
			return v;
		endfunction

		// exact product, floored shift, clamped
		function longint frac_mul(longint a, longint b, int sh);
			longint p;
			p = a * b;
			return clamp_state(p >>> sh);
		endfunction

		// one pass of the filter update, returns the selected response
		function longint half_step(longint x);
			longint band;
			longint notch;
			longint high;
			longint sq;
			longint cube;
			band = band_acc;
			notch = clamp_state(x - frac_mul(damp, band, COEF_FRAC_BITS));
			low_acc = clamp_state(low_acc + frac_mul(freq, band, COEF_FRAC_BITS));
			high = clamp_state(notch - low_acc);
			sq = frac_mul(band, band, STATE_FRAC_BITS);
			cube = frac_mul(sq, band, STATE_FRAC_BITS);
			band_acc = clamp_state(frac_mul(freq, high, COEF_FRAC_BITS) + band
				- frac_mul(drive, cube, COEF_FRAC_BITS));
			case (mode)
				MODE_NOTCH: return notch;
				MODE_LOW:   return low_acc;
				MODE_HIGH:  return high;
				MODE_BAND:  return band_acc;
				MODE_PEAK:  return clamp_state(low_acc - high);
				default:    return 0;
			endcase
		endfunction

		// accepted input transaction: run both passes and queue the averaged output
		function void predict_sample(logic signed [SAMPLE_WIDTH-1:0] s, logic present);
			longint x;
			longint y;
			longint top;
			x = present ? longint'(s) : 0;
			y = half_step(x);
			y = (y + half_step(x)) >>> 1;
			top = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
			if (y > top)
				y = top;
			if (y < -top - 1)
				y = -top - 1;
			expected_out.push_back(y[SAMPLE_WIDTH-1:0]);
		endfunction

		function int pending();
			return expected_out.size();
		endfunction

		task report(string msg);
			$display("mismatch @%0t: %s", $time, msg);
			mismatches++;
		endtask

		// accepted output transaction against the oldest expectation
		task check_sample_out(logic signed [SAMPLE_WIDTH-1:0] got);
			logic signed [SAMPLE_WIDTH-1:0] want;
			if (expected_out.size() == 0) begin
				report($sformatf("unexpected sample_out %0d", got));
			end else begin
				want = expected_out.pop_front();
				compared++;
				if (got !== want)
					report($sformatf("sample_out %0d, expected %0d", got, want));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [REG_IDX_W-1:0] cfg_addr;
	logic [COEF_WIDTH-1:0] cfg_wdata;

	svf_in_if  in_if();
	svf_out_if out_if();

	double_sampled_svf_filter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.din       (in_if),
		.dout      (out_if)
	);

	svf_checker sb = new();

	int tx_idle_pct = 36;
	int rx_idle_pct = 50;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int holds_done = 0;
	int cycles = 0;
	int samples_sent = 0;
	int settings_used = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
			$display("TB_ERROR");
			$finish;
		end
	end

	// input monitor
	always @(posedge clk) begin
		if (arst_n && in_if.valid && in_if.ready)
			sb.predict_sample(in_if.sample_in, in_if.in_present);
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready)
			sb.check_sample_out(out_if.sample_out);
	end

	// receiver: random back-pressure plus long hold-off stretches on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
			holds_done++;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// one register write, predictor follows at the same edge
	task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [COEF_WIDTH-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// full filter setting, written only while idle
	task automatic load_setting(input logic [COEF_WIDTH-1:0] mode_word,
		input logic [COEF_WIDTH-1:0] freq_word, input logic [COEF_WIDTH-1:0] damp_word,
		input logic [COEF_WIDTH-1:0] drive_word);
		put_reg(REG_FILTER_MODE, mode_word);
		put_reg(REG_FREQ_COEF, freq_word);
		put_reg(REG_DAMP_COEF, damp_word);
		put_reg(REG_DRIVE_COEF, drive_word);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// pause the sender until every expected result has come back
	task automatic wait_idle();
		in_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// offer one input transaction and hold it until accepted
	task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic present);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.sample_in <= s;
		in_if.in_present <= present;
		do
			@(posedge clk);
		while (!in_if.ready);
		samples_sent++;
	endtask

	function automatic logic [COEF_WIDTH-1:0] pick_coef();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return w[COEF_WIDTH-1:0];
			default: return COEF_WIDTH'($urandom_range(32'h400000));
		endcase
	endfunction

	// drive word with random junk above the register width
	function automatic logic [COEF_WIDTH-1:0] pick_drive();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(3))
			0: w[DRIVE_WIDTH-1:0] = '0;
			1: w[DRIVE_WIDTH-1:0] = DRIVE_WIDTH'(DRIVE_TOP);
			2: w[DRIVE_WIDTH-1:0] = '1;
			default: w[DRIVE_WIDTH-1:0] = DRIVE_WIDTH'($urandom_range(DRIVE_TOP));
		endcase
		return w[COEF_WIDTH-1:0];
	endfunction

	// mostly real responses, sometimes an unused code, junk above the mode bits
	function automatic logic [COEF_WIDTH-1:0] pick_mode();
		logic [31:0] w;
		w = $urandom;
		w[MODE_WIDTH-1:0] = MODE_WIDTH'(($urandom_range(3) == 0) ? $urandom_range(7) :
			$urandom_range(4));
		return w[COEF_WIDTH-1:0];
	endfunction

	// input waveform: noise, square wave, or a mix of extremes and small values
	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(int style, int idx,
		int amp, int period);
		logic [31:0] w;
		int r;
		w = $urandom;
		r = $urandom_range(99);
		case (style)
			0: return w[SAMPLE_WIDTH-1:0];
			1: return SAMPLE_WIDTH'(((idx / period) % 2 == 1) ? amp : -amp);
			default: begin
				if (r < 20)
					return w[0] ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} :
						{1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
				else if (r < 50)
					return SAMPLE_WIDTH'(int'($urandom_range(512)) - 256);
				else
					return w[SAMPLE_WIDTH-1:0];
			end
		endcase
	endfunction

	// main sequence
	initial begin
		int m;
		int ph;
		int i;
		int amp;
		int period;
		logic signed [SAMPLE_WIDTH-1:0] s_max;
		logic signed [SAMPLE_WIDTH-1:0] s_min;
		logic [31:0] w;

		s_max = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		s_min = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		in_if.valid <= 1'b0;
		in_if.sample_in <= '0;
		in_if.in_present <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: full-scale samples, zero, an absent input carrying a value
		send_sample(s_max, 1'b1);
		send_sample(s_min, 1'b1);
		send_sample('0, 1'b1);
		send_sample(s_max, 1'b0);
		send_sample('1, 1'b1);

		// every response code including the unused ones, with drive at its top
		for (m = 0; m <= 7; m++) begin
			wait_idle();
			load_setting(COEF_WIDTH'(m), 24'h400000, 24'h200000, COEF_WIDTH'(DRIVE_TOP));
			send_sample(m[0] ? s_min : s_max, 1'b1);
			w = $urandom;
			send_sample(w[SAMPLE_WIDTH-1:0], 1'b1);
		end

		// unstable setting: band integrator rails, square saturates, drive above range
		wait_idle();
		load_setting(COEF_WIDTH'(MODE_BAND), '1, '0, '1);
		repeat (4) send_sample(s_max, 1'b1);

		// random phases, each with its own filter setting and idling pattern
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			case (ph / 4)
				0: begin
					tx_idle_pct = 36;
					rx_idle_pct = 50;
				end
				1: begin
					tx_idle_pct = 50;
					rx_idle_pct = 36;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			if (ph == 0)
				load_setting(COEF_WIDTH'(MODE_PEAK), '1, '0, COEF_WIDTH'(DRIVE_TOP));
			else if (ph == 1)
				load_setting(COEF_WIDTH'(MODE_NOTCH), '0, '1, '0);
			else
				load_setting(pick_mode(), pick_coef(), pick_coef(), pick_drive());
			// output stalls long enough that the block backs up into its input
			if (ph == 1 || ph == 6 || ph == 9)
				hold_req = 1'b1;
			amp = $urandom_range(8388607);
			period = $urandom_range(2, 40);
			for (i = 0; i < PHASE_ITEMS; i++)
				send_sample(pick_sample(ph % 3, i, amp, period), $urandom_range(9) != 0);
		end

		// drain and settle
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (sb.pending() != 0)
			sb.report($sformatf("missing sample_out, expected %0d", sb.expected_out.pop_front()));

		$display("%0d samples under %0d filter settings, %0d outputs compared, %0d mismatches",
			samples_sent, settings_used, sb.compared, sb.mismatches);
		$display("all responses and unused codes, coefficient extremes, %0d long output stalls",
			holds_done);
		if (sb.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
